/* src/ata_pkg.sv */
package ata_pkg;

  localparam int unsigned WINDOW_LEN_DEF = 8;

  localparam int unsigned ADC_W    = 10;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned TEMP_W   = 17;
  localparam int unsigned THR_W    = 17;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned LEVEL_W  = 2;

  localparam int unsigned QUO_W      = 16;
  localparam int unsigned STEP_W     = 5;
  localparam int unsigned MEAN_STEPS = ADC_W;

  localparam int unsigned SCALE_MUL = 50000;
  localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 17'sd5000;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [THR_W-1:0]    ATTN_RST   = 17'd3500;
  localparam logic [THR_W-1:0]    DANGER_RST = 17'd4200;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd800;

  typedef enum logic [1:0] {
    REG_ATTN   = 2'd0,
    REG_DANGER = 2'd1,
    REG_PERIOD = 2'd2
  } cfg_reg_e;

  typedef enum logic [LEVEL_W-1:0] {
    LVL_NORMAL = 2'd0,
    LVL_ATTN   = 2'd1,
    LVL_DANGER = 2'd2
  } level_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_TSTART,
    ST_TWAIT,
    ST_MSTART,
    ST_MWAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [THR_W-1:0]    attn_thr;
    logic [THR_W-1:0]    danger_thr;
    logic [PERIOD_W-1:0] blink_period;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

endpackage

/* src/ata_in_if.sv */
interface ata_in_if;
  logic                      valid;
  logic                      ready;
  logic [ata_pkg::ADC_W-1:0]  adc_sample;
  logic [ata_pkg::TIME_W-1:0] time_ms;

  modport source (output valid, output adc_sample, output time_ms, input ready);
  modport sink (input valid, input adc_sample, input time_ms, output ready);
endinterface

/* src/ata_out_if.sv */
interface ata_out_if;
  logic                              valid;
  logic                              ready;
  logic [ata_pkg::ADC_W-1:0]         mean_adc;
  logic signed [ata_pkg::TEMP_W-1:0] temp_centi;
  logic [ata_pkg::LEVEL_W-1:0]       level;
  logic                              led_on;

  modport source (output valid, output mean_adc, output temp_centi, output level,
                  output led_on, input ready);
  modport sink (input valid, input mean_adc, input temp_centi, input level,
                input led_on, output ready);
endinterface

/* src/ata_cfg.sv */
module ata_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ata_pkg::PADDR_W-1:0]  paddr,
  input  logic [ata_pkg::PDATA_W-1:0]  pwdata,
  output logic [ata_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output ata_pkg::cfg_t                cfg_o
);

  ata_pkg::cfg_t    cfg_q;
  ata_pkg::cfg_reg_e reg_sel;
  logic             wr_en;

  assign reg_sel = ata_pkg::cfg_reg_e'(paddr[ata_pkg::PADDR_W-1:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attn_thr     <= ata_pkg::ATTN_RST;
      cfg_q.danger_thr   <= ata_pkg::DANGER_RST;
      cfg_q.blink_period <= ata_pkg::PERIOD_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        ata_pkg::REG_ATTN:   cfg_q.attn_thr     <= pwdata[ata_pkg::THR_W-1:0];
        ata_pkg::REG_DANGER: cfg_q.danger_thr   <= pwdata[ata_pkg::THR_W-1:0];
        ata_pkg::REG_PERIOD: cfg_q.blink_period <= pwdata[ata_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ata_pkg::REG_ATTN:
        prdata = {{(ata_pkg::PDATA_W-ata_pkg::THR_W){1'b0}}, cfg_q.attn_thr};
      ata_pkg::REG_DANGER:
        prdata = {{(ata_pkg::PDATA_W-ata_pkg::THR_W){1'b0}}, cfg_q.danger_thr};
      ata_pkg::REG_PERIOD:
        prdata = {{(ata_pkg::PDATA_W-ata_pkg::PERIOD_W){1'b0}}, cfg_q.blink_period};
      default: prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* src/ata_ring.sv */
module ata_ring #(
  parameter int unsigned WINDOW_LEN = ata_pkg::WINDOW_LEN_DEF
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              push_i,
  input  logic [ata_pkg::ADC_W-1:0]                          sample_i,
  output logic [$clog2(WINDOW_LEN+1)-1:0]                    count_o,
  output logic [ata_pkg::ADC_W+$clog2(WINDOW_LEN+1)-1:0]     sum_o,
  output logic                                              done_o
);

  localparam int unsigned CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int unsigned IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned SUM_W = ata_pkg::ADC_W + CNT_W;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW_LEN - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(WINDOW_LEN);

  logic [ata_pkg::ADC_W-1:0] mem [WINDOW_LEN];
  logic [ata_pkg::ADC_W-1:0] rd_data_q;
  logic [IDX_W-1:0]          slot_q;
  logic [CNT_W-1:0]          count_q;
  logic [CNT_W-1:0]          rd_idx_q;
  logic                      run_q;
  logic                      rd_vld_q;
  logic [SUM_W-1:0]          acc_q;
  logic                      rd_more;

  assign rd_more = run_q && (rd_idx_q < count_q);
  assign done_o  = run_q && !rd_more && !rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[slot_q] <= sample_i;
    end
    if (rd_more) begin
      rd_data_q <= mem[rd_idx_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      count_q  <= '0;
      rd_idx_q <= '0;
      run_q    <= 1'b0;
      rd_vld_q <= 1'b0;
      acc_q    <= '0;
    end else if (push_i) begin
      slot_q   <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
      count_q  <= (count_q == FULL_CNT) ? count_q : count_q + 1'b1;
      rd_idx_q <= '0;
      run_q    <= 1'b1;
      rd_vld_q <= 1'b0;
      acc_q    <= '0;
    end else if (run_q) begin
      rd_vld_q <= rd_more;
      if (rd_more) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (rd_vld_q) begin
        acc_q <= acc_q + SUM_W'(rd_data_q);
      end
      if (done_o) begin
        run_q <= 1'b0;
      end
    end
  end

  assign count_o = count_q;
  assign sum_o   = acc_q;

  sum_done_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> count_q != '0)
    else $error("sum finished over an empty window");

  read_within_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> rd_idx_q <= count_q && rd_idx_q != '0)
    else $error("ring read outside the filled slots");

  push_clears_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |=> run_q && acc_q == '0 && rd_idx_q == '0)
    else $error("summation did not restart on push");

endmodule

/* src/ata_div.sv */
module ata_div #(
  parameter int unsigned DVS_W = ata_pkg::ADC_W + 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ata_pkg::div_ctl_t           ctl_i,
  input  logic [DVS_W-1:0]            rem_init_i,
  input  logic [ata_pkg::QUO_W-1:0]   bits_i,
  input  logic [DVS_W-1:0]            divisor_i,
  output logic [ata_pkg::QUO_W-1:0]   quotient_o,
  output logic                        done_o
);

  logic [DVS_W-1:0]          rem_q;
  logic [DVS_W-1:0]          dvs_q;
  logic [ata_pkg::QUO_W-1:0] bits_q;
  logic [ata_pkg::QUO_W-1:0] quo_q;
  logic [ata_pkg::STEP_W-1:0] step_q;
  logic                      busy_q;
  logic [DVS_W:0]            trial;
  logic [DVS_W:0]            diff;
  logic                      fits;

  assign trial = {rem_q, bits_q[ata_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rem_q  <= rem_init_i;
      dvs_q  <= divisor_i;
      bits_q <= bits_i;
      quo_q  <= '0;
    end else if (busy_q && step_q != '0) begin
      rem_q  <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      bits_q <= {bits_q[ata_pkg::QUO_W-2:0], 1'b0};
      quo_q  <= {quo_q[ata_pkg::QUO_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      step_q <= ctl_i.steps;
    end else if (busy_q) begin
      if (step_q != '0) begin
        step_q <= step_q - 1'b1;
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  assign done_o     = busy_q && (step_q == '0);
  assign quotient_o = quo_q;

  done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !ctl_i.start |=> !busy_q)
    else $error("divider stayed busy after finishing");

  remainder_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && step_q != '0 |-> rem_q < dvs_q)
    else $error("partial remainder not below divisor");

  steps_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> ctl_i.steps <= ata_pkg::STEP_W'(ata_pkg::QUO_W))
    else $error("divider asked for more steps than quotient bits");

endmodule

/* src/averaged_temperature_alarm.sv */
// Averaged temperature alarm.
// Input channel sample_i (valid/ready) carries one 10-bit converter reading and a
// millisecond timestamp per beat. Output channel result_o carries, per input beat,
// the truncated mean over the filled window slots, the temperature in hundredths
// of a degree Celsius (floored), the alarm level and the LED drive.
// Thresholds and the blink period sit behind an APB port (psel/penable/pwrite,
// one register every 4 bytes); write them only while no beat is in flight.
// One beat is handled at a time: sample_i.ready is high only in idle.
// A beat passes through one ring read per filled slot, one multiply, then one
// shared restoring divider running 16 steps for the temperature and 10 steps
// for the mean. The next beat is taken in the first cycle its predecessor's
// result can leave.
// A finished result waits in the output register; the next beat is taken
// meanwhile and its result is held until result_o.ready frees the register.
// Reset empties the window, loads the default thresholds (35.00 C, 42.00 C)
// and blink period (800 ms), and turns the LED off.
module averaged_temperature_alarm #(
  parameter int unsigned WINDOW_LEN = ata_pkg::WINDOW_LEN_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ata_in_if.sink                      sample_i,
  ata_out_if.source                   result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ata_pkg::PADDR_W-1:0] paddr,
  input  logic [ata_pkg::PDATA_W-1:0] pwdata,
  output logic [ata_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int unsigned CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int unsigned SUM_W = ata_pkg::ADC_W + CNT_W;
  localparam int unsigned SCL_W = SUM_W + ata_pkg::QUO_W;

  ata_pkg::cfg_t     cfg;
  ata_pkg::state_e   state_q, state_d;
  ata_pkg::div_ctl_t div_ctl;
  ata_pkg::level_e   level;

  logic                       accept;
  logic                       out_free;
  logic                       emit;
  logic [CNT_W-1:0]           count;
  logic [SUM_W-1:0]           ring_sum;
  logic                       sum_done;
  logic [SUM_W-1:0]           sum_q;
  logic [SCL_W-1:0]           scaled_q;
  logic [SUM_W-1:0]           big_dvs_q;
  logic [ata_pkg::TIME_W-1:0] time_q;
  logic [ata_pkg::QUO_W-1:0]  quo_t_q;
  logic [ata_pkg::QUO_W-1:0]  quotient;
  logic                       div_done;
  logic [SUM_W-1:0]           rem_init;
  logic [ata_pkg::QUO_W-1:0]  div_bits;
  logic [SUM_W-1:0]           divisor;

  logic signed [ata_pkg::TEMP_W-1:0] temp;
  logic [ata_pkg::TIME_W-1:0]        elapsed;
  logic                              toggle;
  logic                              led_d;
  logic                              phase_q, led_q;
  logic [ata_pkg::TIME_W-1:0]        last_q;

  logic                              out_valid_q;
  logic [ata_pkg::ADC_W-1:0]         out_mean_q;
  logic signed [ata_pkg::TEMP_W-1:0] out_temp_q;
  ata_pkg::level_e                   out_level_q;
  logic                              out_led_q;

  ata_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ata_ring #(.WINDOW_LEN(WINDOW_LEN)) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept),
    .sample_i (sample_i.adc_sample),
    .count_o  (count),
    .sum_o    (ring_sum),
    .done_o   (sum_done)
  );

  ata_div #(.DVS_W(SUM_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .rem_init_i (rem_init),
    .bits_i     (div_bits),
    .divisor_i  (divisor),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  assign accept   = sample_i.valid && sample_i.ready;
  assign out_free = !out_valid_q || result_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ata_pkg::ST_IDLE:   if (accept) state_d = ata_pkg::ST_SUM;
      ata_pkg::ST_SUM:    if (sum_done) state_d = ata_pkg::ST_MUL;
      ata_pkg::ST_MUL:    state_d = ata_pkg::ST_TSTART;
      ata_pkg::ST_TSTART: state_d = ata_pkg::ST_TWAIT;
      ata_pkg::ST_TWAIT:  if (div_done) state_d = ata_pkg::ST_MSTART;
      ata_pkg::ST_MSTART: state_d = ata_pkg::ST_MWAIT;
      ata_pkg::ST_MWAIT:  if (div_done) state_d = ata_pkg::ST_EMIT;
      ata_pkg::ST_EMIT:   if (out_free) state_d = ata_pkg::ST_IDLE;
      default:            state_d = ata_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sample_i.ready = 1'b0;
    div_ctl        = '0;
    emit           = 1'b0;
    rem_init       = scaled_q[SCL_W-1:ata_pkg::QUO_W];
    div_bits       = scaled_q[ata_pkg::QUO_W-1:0];
    divisor        = big_dvs_q;
    unique case (state_q)
      ata_pkg::ST_IDLE: sample_i.ready = 1'b1;
      ata_pkg::ST_TSTART: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = ata_pkg::STEP_W'(ata_pkg::QUO_W);
      end
      ata_pkg::ST_MSTART: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = ata_pkg::STEP_W'(ata_pkg::MEAN_STEPS);
      end
      ata_pkg::ST_EMIT: emit = out_free;
      default: ;
    endcase
    if (state_q == ata_pkg::ST_MSTART) begin
      rem_init = {{ata_pkg::ADC_W{1'b0}}, sum_q[SUM_W-1:ata_pkg::ADC_W]};
      div_bits = {sum_q[ata_pkg::ADC_W-1:0], {(ata_pkg::QUO_W-ata_pkg::ADC_W){1'b0}}};
      divisor  = {{ata_pkg::ADC_W{1'b0}}, count};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ata_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      time_q <= sample_i.time_ms;
    end
    if (state_q == ata_pkg::ST_SUM && sum_done) begin
      sum_q <= ring_sum;
    end
    if (state_q == ata_pkg::ST_MUL) begin
      scaled_q  <= SCL_W'(sum_q) * SCL_W'(ata_pkg::SCALE_MUL);
      big_dvs_q <= {count, {ata_pkg::ADC_W{1'b0}}} - {{ata_pkg::ADC_W{1'b0}}, count};
    end
    if (state_q == ata_pkg::ST_TWAIT && div_done) begin
      quo_t_q <= quotient;
    end
  end

  assign temp    = $signed({1'b0, quo_t_q}) - ata_pkg::TEMP_OFFSET;
  assign elapsed = time_q - last_q;
  assign toggle  = (level == ata_pkg::LVL_ATTN) &&
                   (elapsed >= {{(ata_pkg::TIME_W-ata_pkg::PERIOD_W){1'b0}},
                                cfg.blink_period});

  always_comb begin
    priority if (temp >= $signed(cfg.danger_thr)) begin
      level = ata_pkg::LVL_DANGER;
    end else if (temp >= $signed(cfg.attn_thr)) begin
      level = ata_pkg::LVL_ATTN;
    end else begin
      level = ata_pkg::LVL_NORMAL;
    end
  end

  always_comb begin
    unique case (level)
      ata_pkg::LVL_DANGER: led_d = 1'b1;
      ata_pkg::LVL_ATTN:   led_d = toggle ? !phase_q : led_q;
      default:             led_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      led_q       <= 1'b0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        led_q       <= led_d;
        out_valid_q <= 1'b1;
        if (toggle) begin
          phase_q <= !phase_q;
          last_q  <= time_q;
        end
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_mean_q  <= quotient[ata_pkg::ADC_W-1:0];
      out_temp_q  <= temp;
      out_level_q <= level;
      out_led_q   <= led_d;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.mean_adc   = out_mean_q;
  assign result_o.temp_centi = out_temp_q;
  assign result_o.level      = out_level_q;
  assign result_o.led_on     = out_led_q;

  danger_lights_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.level == ata_pkg::LVL_DANGER |-> result_o.led_on)
    else $error("danger result with LED off");

  normal_darkens_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.level == ata_pkg::LVL_NORMAL |-> !result_o.led_on)
    else $error("normal result with LED on");

  accept_starts_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ata_pkg::ST_SUM)
    else $error("accepted beat did not start summation");

  emit_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q && state_q == ata_pkg::ST_IDLE && out_led_q == led_q)
    else $error("result not registered on emit");

endmodule
